/* sv/esus_pkg.sv */
`timescale 1ns / 1ps
package esus_pkg;

  localparam int BYTE_W     = 8;
  localparam int RAW_W      = 16;
  localparam int SMP12_W    = 12;
  localparam int ZERO_W     = 16;
  localparam int GAIN_W     = 25;
  localparam int PHYS_W     = 42;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int NIB_SHIFT  = 4;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [BYTE_W-1:0] NIB_HI = 8'hF0;
  localparam logic [BYTE_W-1:0] NIB_LO = 8'h0F;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_ZERO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RECIP  = 2'd2;

  // Sample formats.
  localparam logic FMT_16  = 1'b0;
  localparam logic FMT_212 = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 25'd16777216;

  typedef struct packed {
    logic                    channel;
    logic signed [RAW_W-1:0] raw;
  } sample_t;

endpackage

/* sv/esus_if.sv */
`timescale 1ns / 1ps
interface esus_in_if;
  logic                          valid;
  logic                          ready;
  logic [esus_pkg::BYTE_W-1:0]   data_byte;
  logic                          restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface esus_out_if;
  logic                               valid;
  logic                               ready;
  logic                               channel;
  logic signed [esus_pkg::RAW_W-1:0]  raw_sample;
  logic signed [esus_pkg::PHYS_W-1:0] physical_value;

  modport source (output valid, output channel, output raw_sample, output physical_value,
                  input ready);
  modport sink   (input valid, input channel, input raw_sample, input physical_value,
                  output ready);
endinterface

interface esus_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [esus_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [esus_pkg::CFG_DATA_W-1:0]   wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* sv/esus_front.sv */
`timescale 1ns / 1ps
module esus_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           format_mode,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [esus_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           restart,
  input  logic                           q_full,
  output logic                           q_push,
  output esus_pkg::sample_t              q_data
);
  import esus_pkg::*;

  typedef enum logic [1:0] {PH_0, PH_1, PH_2, PH_3} phase_t;

  phase_t              phase_r, phase_nxt, ph;
  logic [BYTE_W-1:0]   first_r, first_nxt;
  logic [BYTE_W-1:0]   second_r, second_nxt;
  logic                accept;
  logic                emit;
  logic [SMP12_W-1:0]  v12;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ph         = restart ? PH_0 : phase_r;
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    emit       = 1'b0;
    v12        = '0;
    q_data     = '0;
    if (format_mode == FMT_16) begin
      phase_nxt = phase_t'(ph + 2'd1);
      if (ph == PH_0 || ph == PH_2) begin
        first_nxt = data_byte;
      end else begin
        emit           = 1'b1;
        q_data.channel = (ph == PH_3);
        q_data.raw     = $signed({data_byte, first_r});
      end
    end else begin
      // Phase three only follows a format switch mid-frame; it restarts the frame.
      case (ph)
        PH_1: begin
          second_nxt     = data_byte;
          v12            = {data_byte[NIB_SHIFT-1:0] & NIB_LO[NIB_SHIFT-1:0], first_r};
          emit           = 1'b1;
          q_data.channel = 1'b0;
          q_data.raw     = $signed({{(RAW_W-SMP12_W){v12[SMP12_W-1]}}, v12});
          phase_nxt      = PH_2;
        end
        PH_2: begin
          v12            = {second_r[BYTE_W-1:NIB_SHIFT], data_byte};
          emit           = 1'b1;
          q_data.channel = 1'b1;
          q_data.raw     = $signed({{(RAW_W-SMP12_W){v12[SMP12_W-1]}}, v12});
          phase_nxt      = PH_0;
        end
        default: begin
          first_nxt = data_byte;
          phase_nxt = PH_1;
        end
      endcase
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_0;
      first_r  <= '0;
      second_r <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_restart_212_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && restart && format_mode == FMT_212) |-> !q_push)
    else $error("restart byte in format 212 produced a sample");
  a_push_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_valid && !q_full))
    else $error("sample pushed without an accepted item");
  a_212_never_phase3: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && format_mode == FMT_212) |=> (phase_r != PH_3))
    else $error("format 212 left phase three");
`endif

endmodule

/* sv/esus_queue.sv */
`timescale 1ns / 1ps
module esus_queue #(
  parameter int DEPTH = esus_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  esus_pkg::sample_t push_data,
  output logic              full,
  input  logic              pop,
  output esus_pkg::sample_t pop_data,
  output logic              empty
);
  import esus_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sample_t             mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not shrink on pop");
`endif

endmodule

/* sv/esus_back.sv */
`timescale 1ns / 1ps
module esus_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [esus_pkg::ZERO_W-1:0] adc_zero,
  input  logic [esus_pkg::GAIN_W-1:0]        gain_recip,
  input  logic                              q_empty,
  input  esus_pkg::sample_t                 q_data,
  output logic                              q_pop,
  esus_out_if.source                        out_ch
);
  import esus_pkg::*;

  localparam int DIFF_W = RAW_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;

  logic                     s1_v_r;
  sample_t                  s1_smp_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod;
  logic                     s2_v_r;
  logic                     s2_ch_r;
  logic signed [RAW_W-1:0]  s2_raw_r;
  logic signed [PHYS_W-1:0] s2_phys_r;
  logic                     s2_take, s1_take;

  // Stage two is the output register; stage one feeds it whenever it frees up.
  assign s2_take = !s2_v_r || out_ch.ready;
  assign s1_take = !s1_v_r || s2_take;
  assign q_pop   = !q_empty && s1_take;

  assign prod = diff_r * $signed({1'b0, gain_recip});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_v_r <= q_pop;
      end
      if (s2_take) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_smp_r <= q_data;
      diff_r   <= $signed({q_data.raw[RAW_W-1], q_data.raw})
                - $signed({adc_zero[ZERO_W-1], adc_zero});
    end
    if (s2_take && s1_v_r) begin
      s2_ch_r   <= s1_smp_r.channel;
      s2_raw_r  <= s1_smp_r.raw;
      s2_phys_r <= prod[PHYS_W-1:0];
    end
  end

  assign out_ch.valid          = s2_v_r;
  assign out_ch.channel        = s2_ch_r;
  assign out_ch.raw_sample     = s2_raw_r;
  assign out_ch.physical_value = s2_phys_r;

`ifndef NO_ASSERTIONS
  a_pop_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s1_v_r)
    else $error("popped sample missing from stage one");
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_take) |=> s2_v_r)
    else $error("stage one sample did not reach the output");
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_take) |=> (s1_v_r && $stable(diff_r)))
    else $error("stalled stage one sample was lost");
`endif

endmodule

/* sv/ecg_sample_unpack_scale.sv */
`timescale 1ns / 1ps
// A byte that completes a sample is written into the sample queue; the sample then passes
// through the scaler's input register and its output register before it is offered on the output.
// Throughput: one byte per cycle, sustained while the output is taken every cycle;
// the sample queue between decoder and scaler absorbs short output stalls.
// Reset (synchronous, active low): byte phase returns to frame start, registers take
// their reset values and the queue and scaler pipeline empty. No clearing pass.
module ecg_sample_unpack_scale #(
  parameter int QUEUE_DEPTH = esus_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  esus_in_if.sink    in_ch,
  esus_out_if.source out_ch,
  esus_cfg_if.sink   cfg_ch
);
  import esus_pkg::*;

  logic                     format_mode_r;
  logic signed [ZERO_W-1:0] adc_zero_r;
  logic [GAIN_W-1:0]        gain_recip_r;
  logic                     q_push, q_pop, q_full, q_empty;
  sample_t                  q_wdata, q_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r <= FMT_212;
      adc_zero_r    <= '0;
      gain_recip_r  <= GAIN_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_FORMAT_MODE: format_mode_r <= cfg_ch.wr_data[0];
        REG_ADC_ZERO:    adc_zero_r    <= $signed(cfg_ch.wr_data[ZERO_W-1:0]);
        REG_GAIN_RECIP:  gain_recip_r  <= cfg_ch.wr_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  esus_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .format_mode (format_mode_r),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .data_byte   (in_ch.data_byte),
    .restart     (in_ch.restart),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  esus_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  esus_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .adc_zero   (adc_zero_r),
    .gain_recip (gain_recip_r),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

/* tb/tb_ecg_sample_unpack_scale.sv */
`timescale 1ns / 1ps
module tb_ecg_sample_unpack_scale;
  import esus_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 500;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_BYTES   = 155;

  typedef struct packed {
    logic                     channel;
    logic signed [RAW_W-1:0]  raw;
    logic signed [PHYS_W-1:0] phys;
  } scaled_sample_t;

  // Tracks the decoder state and the scaling registers, and holds the samples
  // that the block still owes.
  class sample_tracker;
    logic                     fmt;
    logic signed [ZERO_W-1:0] zero;
    logic [GAIN_W-1:0]        gain;
    logic [1:0]               phase;
    logic [BYTE_W-1:0]        held_lo;
    logic [BYTE_W-1:0]        held_mid;
    scaled_sample_t           samples_due[$];
    int                       errors;
    int                       matched;

    function new();
      fmt      = FMT_212;
      zero     = '0;
      gain     = GAIN_RESET;
      phase    = 2'd0;
      held_lo  = '0;
      held_mid = '0;
      errors   = 0;
      matched  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FORMAT_MODE: fmt = data[0];
        REG_ADC_ZERO:    zero = data[ZERO_W-1:0];
        REG_GAIN_RECIP:  gain = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void owe_sample(logic ch, logic signed [RAW_W-1:0] raw);
      scaled_sample_t s;
      longint diff;
      longint prod;
      diff = longint'(raw) - longint'(zero);
      prod = diff * longint'({1'b0, gain});
      s.channel = ch;
      s.raw     = raw;
      s.phys    = prod[PHYS_W-1:0];
      samples_due.push_back(s);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b, logic restart);
      logic [1:0]         ph;
      logic [SMP12_W-1:0] v12;
      ph = restart ? 2'd0 : phase;
      if (fmt == FMT_16) begin
        if (ph == 2'd0 || ph == 2'd2) begin
          held_lo = b;
        end else begin
          owe_sample(ph == 2'd3, {b, held_lo});
        end
        phase = ph + 2'd1;
      end else begin
        // A frame left at its last byte by a format change starts over here.
        if (ph == 2'd3) ph = 2'd0;
        case (ph)
          2'd0: begin
            held_lo = b;
            phase   = 2'd1;
          end
          2'd1: begin
            held_mid = b;
            v12      = {b[3:0], held_lo};
            owe_sample(1'b0, {{(RAW_W-SMP12_W){v12[SMP12_W-1]}}, v12});
            phase    = 2'd2;
          end
          default: begin
            v12   = {held_mid[7:4], b};
            owe_sample(1'b1, {{(RAW_W-SMP12_W){v12[SMP12_W-1]}}, v12});
            phase = 2'd0;
          end
        endcase
      end
    endfunction

    function void match_sample(logic ch, logic signed [RAW_W-1:0] raw,
                               logic signed [PHYS_W-1:0] phys);
      scaled_sample_t s;
      if (samples_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample ch=%0d raw=%0d phys=%0d", $time, ch, raw, phys);
      end else begin
        s = samples_due.pop_front();
        if (s.channel !== ch || s.raw !== raw || s.phys !== phys) begin
          errors++;
          $display("%0t: sample mismatch expected ch=%0d raw=%0d phys=%0d, got ch=%0d raw=%0d phys=%0d",
                   $time, s.channel, s.raw, s.phys, ch, raw, phys);
        end else begin
          matched++;
        end
      end
    endfunction

    function int pending();
      return samples_due.size();
    endfunction

    function void flag_leftovers();
      if (samples_due.size() != 0) begin
        errors += samples_due.size();
        $display("%0t: %0d samples never came, first expected ch=%0d raw=%0d phys=%0d",
                 $time, samples_due.size(), samples_due[0].channel, samples_due[0].raw,
                 samples_due[0].phys);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic no_gaps;
  int   bytes_fed = 0;
  int   cfg_writes = 0;
  int   idle_cycles = 0;
  sample_tracker tracker;

  esus_in_if  in_ch ();
  esus_out_if out_ch ();
  esus_cfg_if cfg_ch ();

  ecg_sample_unpack_scale DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        tracker.match_sample(out_ch.channel, out_ch.raw_sample, out_ch.physical_value);
      end
      if (in_ch.valid && in_ch.ready) begin
        tracker.take_byte(in_ch.data_byte, in_ch.restart);
        bytes_fed++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        tracker.write_register(cfg_ch.reg_index, cfg_ch.wr_data);
        cfg_writes++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_ecg_sample_unpack_scale: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random stalls before each item, none while no_gaps is set.
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic restart);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 5);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.restart   <= restart;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
  endtask

  // Stops the byte stream and waits until every owed sample has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0]       b;
    logic                    rs;
    logic                    fmt;
    logic [ZERO_W-1:0]       zero;
    logic [GAIN_W-1:0]       gain;
    logic [CFG_DATA_W-1:0]   upper;
    logic [BYTE_W-1:0]       edge_bytes[6];
    int                      pos;
    int                      frame_len;

    tracker     = new();
    no_gaps     = 1'b0;
    edge_bytes  = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h0F, 8'hF0};
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.restart    <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_FORMAT_MODE;
    cfg_ch.wr_data   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Format 212 at reset settings: zero, all ones, and the 12-bit extremes.
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h08, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hF7, 1'b0); send_byte(8'h7F, 1'b0);
    // A restart in the middle of a frame realigns to a new frame.
    send_byte(8'hAB, 1'b0); send_byte(8'h12, 1'b1); send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    drain();

    // Format 16 with the widest difference and the largest gain.
    write_reg(REG_FORMAT_MODE, {{(CFG_DATA_W-1){1'b0}}, FMT_16});
    write_reg(REG_ADC_ZERO, 25'h0007FFF);
    write_reg(REG_GAIN_RECIP, 25'h1FFFFFF);
    send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b0);
    // Leave the frame at its last byte, then switch to format 212.
    send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h03, 1'b0);
    drain();
    write_reg(REG_FORMAT_MODE, {{(CFG_DATA_W-1){1'b0}}, FMT_212});
    write_reg(REG_UNUSED, 25'h1FFFFFF);
    send_byte(8'hC4, 1'b0); send_byte(8'h9E, 1'b0); send_byte(8'h3B, 1'b0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin fmt = FMT_16;  zero = 16'h8000; gain = GAIN_RESET;  end
        1: begin fmt = FMT_212; zero = 16'h7FFF; gain = '0;          end
        2: begin fmt = FMT_212; zero = 16'h8000; gain = 25'h1FFFFFF; end
        default: begin
          fmt  = 1'($urandom_range(0, 1));
          zero = 16'($urandom);
          gain = $urandom_range(0, 3) == 0 ? 25'($urandom) : 25'($urandom_range(0, 16777216));
        end
      endcase
      upper = 25'($urandom);
      write_reg(REG_FORMAT_MODE, {upper[CFG_DATA_W-1:1], fmt});
      write_reg(REG_ADC_ZERO, {upper[CFG_DATA_W-1:ZERO_W], zero});
      write_reg(REG_GAIN_RECIP, gain);
      no_gaps   = (p % 3 == 2);
      frame_len = (fmt == FMT_16) ? 4 : 3;
      pos       = 0;
      for (int i = 0; i < PHASE_BYTES; i++) begin
        b = $urandom_range(0, 3) == 0 ? edge_bytes[$urandom_range(0, 5)] : 8'($urandom);
        // Restarts mostly land on frame starts; a few break a frame.
        rs = (pos == 0) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 39) == 0);
        if (rs) pos = 0;
        send_byte(b, rs);
        pos = (pos + 1) % frame_len;
        if (i == PHASE_BYTES / 2 && p % 2 == 1) drain();
      end
      drain();
    end

    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    tracker.flag_leftovers();
    $display("Covered %0d bytes in both formats with %0d register writes; %0d samples matched.",
             bytes_fed, cfg_writes, tracker.matched);
    $display("Settings included zero and maximum gain and both ADC zero extremes.");
    if (tracker.errors == 0) begin
      $display("tb_ecg_sample_unpack_scale: PASS");
    end else begin
      $display("tb_ecg_sample_unpack_scale: FAIL");
    end
    $finish;
  end

endmodule
